>>> src/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the integer-to-decimal converter
// Holds the controller state type, the digit cell operation codes and the
// fixed widths and ASCII codes used by the cells and the top level.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_W  = 32;   // input integer width
  localparam int CHAR_W   = 7;    // ASCII code width
  localparam int DIGIT_W  = 4;    // one BCD digit
  localparam int NUM_DIG  = 10;   // decimal digits of a 32-bit magnitude
  localparam int BITCNT_W = 5;    // counts VALUE_W shift steps
  localparam int NDIG_W   = 4;    // holds 0..NUM_DIG

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_SIGN,
    ST_EMIT
  } itoa_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_DSHIFT
  } itoa_cell_op_t;

endpackage

>>> src/itoa_cell.sv
// ----------------------------------------------------------------------------
// itoa_cell: one BCD digit of the conversion chain
// Add-3 adjust and one-bit shift for double dabble; whole-digit shift
// toward the top of the chain when digits are stripped or emitted.
// ----------------------------------------------------------------------------
module itoa_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  itoa_pkg::itoa_cell_op_t        op,
  input  logic                           bit_in,
  input  logic [itoa_pkg::DIGIT_W-1:0]   digit_in,
  output logic                           bit_out,
  output logic [itoa_pkg::DIGIT_W-1:0]   digit_q
);
  import itoa_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // adjusted digit; its top bit carries into the next cell up
  assign adj     = (digit_r >= DABBLE_LIMIT) ? (digit_r + DABBLE_ADD) : digit_r;
  assign bit_out = adj[DIGIT_W-1];
  assign digit_q = digit_r;

  always_comb begin
    case (op)
      CELL_HOLD:   digit_nxt = digit_r;
      CELL_CLEAR:  digit_nxt = '0;
      CELL_DABBLE: digit_nxt = {adj[DIGIT_W-2:0], bit_in};
      CELL_DSHIFT: digit_nxt = digit_in;
      default:     digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

>>> src/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: 32-bit signed integer to decimal ASCII text
// Flow: a request is taken only in idle, and the block stays busy through
//   the 32 shift steps of the digit chain, the strip phase and the output
//   of the sign, if negative, and the digits, one digit position stripped
//   or emitted per cycle; the next request is taken back in idle.
// Reset: synchronous, active low; returns to idle, nothing kept between
//   requests. Results are strobed one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
//
// Structure
//   - A 32-bit magnitude shift register feeds its MSB into a chain of ten
//     BCD digit cells (double dabble). Each cycle every cell adjusts its own
//     digit (+3 if >= 5) and shifts left one bit, taking its neighbor's
//     carry. No ripple: a cell's carry depends only on its own register.
//   - After 32 steps the chain holds the magnitude in BCD, digit 9 on top.
//   - Leading zeros are stripped by shifting whole digits up the chain, one
//     per cycle, keeping at least one digit.
//   - A '-' goes out first for a negative request, then the top digit is
//     emitted each cycle while the chain shifts up; the final one has last.
//   - Most negative value: two's complement negation gives 0x80000000,
//     which read unsigned is 2147483648, so no special path is needed.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [itoa_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  output logic [itoa_pkg::CHAR_W-1:0]          out_character,
  output logic                                 out_last
);
  import itoa_pkg::*;

  // controller state
  itoa_state_t state_r, state_nxt;

  // request data and counters
  logic [VALUE_W-1:0]  mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic [BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [NDIG_W-1:0]   ndig_r, ndig_nxt;   // digits left in the chain

  // digit chain wiring
  itoa_cell_op_t       cell_op;
  logic [DIGIT_W-1:0]  dig   [NUM_DIG];
  logic                carry [NUM_DIG];
  logic [DIGIT_W-1:0]  top_digit;
  logic                accept;
  logic                conv_done;
  logic                lead_zero;       // top digit is a suppressible zero
  logic                final_digit;

  assign accept      = start && (state_r == ST_IDLE);
  assign conv_done   = (bit_cnt_r == BITCNT_W'(VALUE_W - 1));
  assign top_digit   = dig[NUM_DIG-1];
  assign final_digit = (ndig_r == NDIG_W'(1));
  assign lead_zero   = (top_digit == '0) && !final_digit;

  // --------------------------------------------------------------------------
  // Chain of digit cells. Cell 0 takes the magnitude MSB during conversion
  // and a zero digit when the chain shifts up.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < NUM_DIG; g++) begin : g_cell
    if (g == 0) begin : g_first
      itoa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (cell_op),
        .bit_in   (mag_r[VALUE_W-1]),
        .digit_in ('0),
        .bit_out  (carry[g]),
        .digit_q  (dig[g])
      );
    end else begin : g_rest
      itoa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (cell_op),
        .bit_in   (carry[g-1]),
        .digit_in (dig[g-1]),
        .bit_out  (carry[g]),
        .digit_q  (dig[g])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_nxt = ST_STRIP;
      end
      ST_STRIP: begin
        if (!lead_zero) state_nxt = neg_r ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (final_digit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs, cell operation and datapath updates
  // --------------------------------------------------------------------------
  always_comb begin
    cell_op       = CELL_HOLD;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    ndig_nxt      = ndig_r;
    busy          = 1'b1;
    out_valid     = 1'b0;
    out_character = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
    out_last      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          cell_op     = CELL_CLEAR;
          neg_nxt     = in_value[VALUE_W-1];
          mag_nxt     = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
          bit_cnt_nxt = '0;
          ndig_nxt    = NDIG_W'(NUM_DIG);
        end
      end
      ST_CONV: begin
        cell_op     = CELL_DABBLE;
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BITCNT_W'(1);
      end
      ST_STRIP: begin
        if (lead_zero) begin
          cell_op  = CELL_DSHIFT;
          ndig_nxt = ndig_r - NDIG_W'(1);
        end
      end
      ST_SIGN: begin
        out_valid     = 1'b1;
        out_character = ASCII_MINUS;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        out_last  = final_digit;
        cell_op   = CELL_DSHIFT;
        ndig_nxt  = ndig_r - NDIG_W'(1);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
      ndig_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      ndig_r    <= ndig_nxt;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
  end

endmodule

>>> tb/signed_int_to_decimal_ascii_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb: self-checking bench for the itoa converter
// Drives signed 32-bit requests through the start/busy handshake and checks
// every strobed ASCII character and last flag against an in-bench decimal
// text model or typed row text. A directed table runs first, then random requests.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

  import itoa_pkg::*;

  // One expected output character.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // Directed row. An empty text means the expected characters come from
  // the text model; otherwise the text is the expected output as typed.
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    string                     text;
  } dir_row_t;

  localparam int NUM_DIR    = 22;
  localparam int NUM_RANDOM = 410;
  // Random requests in this window never idle on the request side.
  localparam int BURST_LO   = 100;
  localparam int BURST_HI   = 220;
  // Before this random request, drain every pending character first.
  localparam int DRAIN_AT   = 300;
  // Idle cycles allowed after the last character (about one request time).
  localparam int TAIL_CYCLES = 60;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic [CHAR_W-1:0]         out_character;
  logic                      out_last;

  // Characters still owed by the block, oldest first.
  text_char_t pending_text [$];
  int         fail_count;

  // Extremes, sign handling, zero, digit-count boundaries and bit patterns.
  dir_row_t dir_rows [NUM_DIR] = '{
    '{32'sd0,            "0"},
    '{32'sd1,            "1"},
    '{-32'sd1,           "-1"},
    '{32'sd9,            "9"},
    '{32'sd10,           "10"},
    '{-32'sd10,          ""},
    '{32'sd2147483647,   "2147483647"},
    '{32'h8000_0000,     "-2147483648"},
    '{-32'sd2147483647,  "-2147483647"},
    '{32'sd99,           ""},
    '{32'sd100,          ""},
    '{32'sd1000,         ""},
    '{32'sd999999999,    ""},
    '{32'sd1000000000,   "1000000000"},
    '{-32'sd1000000000,  ""},
    '{-32'sd999999999,   ""},
    '{32'sd123456789,    ""},
    '{-32'sd987654321,   ""},
    '{32'h5555_5555,     ""},
    '{32'hAAAA_AAAA,     ""},
    '{32'sd7,            ""},
    '{-32'sd5,           ""}
  };

  signed_int_to_decimal_ascii DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Text model: sign first, then digits most significant first, leading
  // zeros dropped, last flag on the final digit. The most negative value
  // negates to 0x80000000, which read unsigned is the right magnitude.
  function automatic void queue_decimal_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digs [NUM_DIG];
    int                 nd;
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    nd  = 0;
    do begin
      digs[nd] = DIGIT_W'(mag % 10);
      mag      = mag / 10;
      nd++;
    end while (mag != 0);
    if (v[VALUE_W-1])
      pending_text.push_back('{code: ASCII_MINUS, last: 1'b0});
    for (int i = nd - 1; i >= 0; i--)
      pending_text.push_back('{code: ASCII_ZERO + CHAR_W'(digs[i]), last: (i == 0)});
  endfunction

  // Random value: some fully random words, the rest biased to an even
  // spread of digit counts and to the edges of each power of ten.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned        mode;
    int unsigned        ndig;
    int unsigned        lo;
    int unsigned        hi;
    longint             p;
    logic [VALUE_W-1:0] mag;
    mode = $urandom_range(0, 9);
    if (mode < 3)
      return $urandom;
    ndig = $urandom_range(1, NUM_DIG);
    p = 1;
    repeat (ndig - 1) p = p * 10;
    if (mode < 5) begin
      mag = VALUE_W'(p - 1 + $urandom_range(0, 2));
    end else begin
      lo  = (ndig == 1) ? 0 : int'(p);
      hi  = (ndig == NUM_DIG) ? 32'h8000_0000 : int'(p * 10 - 1);
      mag = $urandom_range(hi, lo);
    end
    if ($urandom_range(0, 1) == 1)
      mag = ~mag + 1'b1;
    return mag;
  endfunction

  task automatic record_failure(input string what);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Called just after a falling edge. Optionally idles first (start low,
  // value wandering), then holds start until the block takes the request.
  // start is left high so a back-to-back request is taken as soon as the block is idle.
  task automatic send_request(input logic [VALUE_W-1:0] v, input bit may_idle);
    int  gap;
    bit  taken;
    if (may_idle && $urandom_range(0, 99) < 10) begin
      // mostly short gaps, now and then one long enough to span a whole
      // conversion so the request lands on every phase of the work
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 4);
      repeat (gap) begin
        start    <= 1'b0;
        in_value <= $urandom;
        @(negedge clk);
      end
    end
    start    <= 1'b1;
    in_value <= v;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      // busy read here is the value before the edge's updates
      taken = !busy;
      if (taken)
        queue_decimal_text(v);
      @(negedge clk);
    end
  endtask

  // Result checker: the receiver cannot stall, so every strobe is consumed.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_text.size() == 0) begin
        record_failure($sformatf("unexpected char %0d last %0b",
                                 out_character, out_last));
      end else if (pending_text[0].code !== out_character ||
                   pending_text[0].last !== out_last) begin
        record_failure($sformatf("expected char %0d last %0b, got char %0d last %0b",
                                 pending_text[0].code, pending_text[0].last,
                                 out_character, out_last));
        void'(pending_text.pop_front());
      end else begin
        void'(pending_text.pop_front());
      end
    end
  end

  // Stimulus
  initial begin
    fail_count = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_value   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: typed rows queue their literal text, the rest use
    // the model. The typed text replaces the model, not checks it.
    for (int r = 0; r < NUM_DIR; r++) begin
      if (dir_rows[r].text.len() == 0) begin
        send_request(dir_rows[r].value, 1'b0);
      end else begin
        // hold the literal until acceptance, then swap it in for the model
        send_request(dir_rows[r].value, 1'b0);
        for (int k = 0; k < dir_rows[r].text.len(); k++)
          void'(pending_text.pop_back());
        for (int k = 0; k < dir_rows[r].text.len(); k++)
          pending_text.push_back('{code: CHAR_W'(dir_rows[r].text[k]),
                                   last: (k == dir_rows[r].text.len() - 1)});
      end
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == DRAIN_AT) begin
        // let the block run dry before the next request
        start <= 1'b0;
        while (pending_text.size() != 0) @(negedge clk);
      end
      send_request(pick_value(), !(n >= BURST_LO && n < BURST_HI));
    end
    start <= 1'b0;

    while (pending_text.size() != 0) @(posedge clk);
    // stray characters in this window are flagged by the checker
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_text.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: fails the run if the 432 requests and their idle gaps have
  // not finished by this time, which leaves a wide margin.
  initial begin
    #6000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
